// ----- design/sal_pkg.sv -----
package sal_pkg;

  localparam int TableDepth = 32;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int FillW      = AddrW + 1;

  localparam logic [7:0] YSkip       = 8'hd1;
  localparam logic [7:0] YTerm       = 8'hd0;
  localparam int         OverflowBit = 6;

  typedef enum logic [2:0] {
    CMD_BEGIN    = 3'd0,
    CMD_ADD      = 3'd1,
    CMD_FINALIZE = 3'd2,
    CMD_COPY     = 3'd3,
    CMD_STATUS   = 3'd4
  } cmd_t;

  typedef enum logic {
    KIND_ACK   = 1'b0,
    KIND_ENTRY = 1'b1
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_COPY
  } state_t;

  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] tile;
    logic [7:0] x;
    logic [7:0] y;
  } entry_t;

endpackage

// ----- design/sprite_attribute_list_builder.sv -----
// Sprite attribute list builder. Commands arrive on the in_ stream with the command code in
// in_tuser: begin frame, add sprite, finalize, copy out and video status. A new command is
// taken every cycle as long as the out_ stream takes the add acknowledges. Copy out streams
// min(MAX_SPRITES + 1, 32) table entries, paced by the registered read of the table memory:
// each entry is loaded onto the out_ stream before the next read is issued, and no command is
// taken until its last beat is loaded. Table entries never written since reset read as zero
// through per-entry valid bits, so no clearing pass follows reset. flicker_enable is
// register 0 on the cfg_ port.
module sprite_attribute_list_builder
  import sal_pkg::*;
#(
  parameter int MAX_SPRITES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // pos_x, pos_y, tile_num, attr_byte, status_byte
  input  logic [2:0]  in_tuser,    // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // accepted, entry_y, entry_x, entry_tile, entry_attr, zeros
  output logic        out_tuser,   // result_kind
  output logic        out_tlast,   // last
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CopyN = (MAX_SPRITES + 1 > TableDepth) ? TableDepth : MAX_SPRITES + 1;

  state_t                state_r, state_nxt;
  logic [FillW-1:0]      fill_r, fill_nxt;
  logic                  parity_r, parity_nxt;
  logic                  flip_r, flip_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  flicker_r, flicker_nxt;
  logic [TableDepth-1:0] valid_r, valid_nxt;
  logic [AddrW-1:0]      cp_addr_r, cp_addr_nxt;
  logic                  cp_done_r, cp_done_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic                  rd_last_r, rd_last_nxt;
  logic                  out_vld_r, out_vld_nxt;
  logic                  out_kind_r, out_kind_nxt;
  logic                  out_acc_r, out_acc_nxt;
  logic                  out_last_r, out_last_nxt;
  entry_t                out_ent_r, out_ent_nxt;

  entry_t                mem [TableDepth];
  entry_t                rdata_r;
  logic                  rvalid_r;
  logic                  rd_en;
  logic                  wr_en;
  logic [3:0]            wr_be;
  logic [AddrW-1:0]      wr_addr;
  entry_t                wr_data;

  logic                  in_fire;
  logic                  out_free;
  cmd_t                  cmd;
  entry_t                in_ent;
  logic                  add_ok;
  logic                  store;
  logic                  cfg_wr;

  assign cmd       = cmd_t'(in_tuser);
  assign in_ent    = '{attr: in_tdata[31:24], tile: in_tdata[23:16],
                       x: in_tdata[7:0], y: in_tdata[15:8]};
  assign out_free  = !out_vld_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign add_ok    = fill_r < FillW'(MAX_SPRITES);

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {31'd0, flicker_r};

  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_ent_r.attr, out_ent_r.tile, out_ent_r.x, out_ent_r.y,
                       out_acc_r};

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    parity_nxt   = parity_r;
    flip_nxt     = flip_r;
    ovf_nxt      = ovf_r;
    flicker_nxt  = cfg_wr ? cfg_pwdata[0] : flicker_r;
    valid_nxt    = valid_r;
    cp_addr_nxt  = cp_addr_r;
    cp_done_nxt  = cp_done_r;
    rd_pend_nxt  = 1'b0;
    rd_last_nxt  = rd_last_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_kind_nxt = out_kind_r;
    out_acc_nxt  = out_acc_r;
    out_last_nxt = out_last_r;
    out_ent_nxt  = out_ent_r;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    wr_be        = 4'hf;
    wr_addr      = fill_r[AddrW-1:0];
    wr_data      = in_ent;
    store        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (cmd)
            CMD_BEGIN: begin
              fill_nxt   = '0;
              parity_nxt = 1'b0;
              flip_nxt   = !flip_r;
            end
            CMD_ADD: begin
              if (add_ok && in_ent.y != YSkip) begin
                parity_nxt = !parity_r;
                store      = !(flicker_r && ovf_r) || (!parity_r == flip_r);
              end
              if (store) begin
                wr_en              = 1'b1;
                valid_nxt[wr_addr] = 1'b1;
                fill_nxt           = fill_r + FillW'(1);
              end
              out_vld_nxt  = 1'b1;
              out_kind_nxt = KIND_ACK;
              out_acc_nxt  = add_ok;
              out_last_nxt = 1'b1;
              out_ent_nxt  = '0;
            end
            CMD_FINALIZE: begin
              if (!fill_r[AddrW]) begin
                wr_en              = 1'b1;
                wr_be              = valid_r[wr_addr] ? 4'h1 : 4'hf;
                wr_data            = '{attr: 8'd0, tile: 8'd0, x: 8'd0, y: YTerm};
                valid_nxt[wr_addr] = 1'b1;
              end
            end
            CMD_COPY: begin
              state_nxt   = ST_COPY;
              cp_addr_nxt = '0;
              cp_done_nxt = 1'b0;
            end
            CMD_STATUS: begin
              ovf_nxt = in_tdata[32 + OverflowBit];
            end
            default: begin
            end
          endcase
        end
      end
      ST_COPY: begin
        if (rd_pend_r) begin
          out_vld_nxt  = 1'b1;
          out_kind_nxt = KIND_ENTRY;
          out_acc_nxt  = 1'b0;
          out_last_nxt = rd_last_r;
          out_ent_nxt  = rvalid_r ? rdata_r : '0;
          if (rd_last_r) begin
            state_nxt = ST_IDLE;
          end
        end else if (!cp_done_r && out_free) begin
          rd_en       = 1'b1;
          rd_pend_nxt = 1'b1;
          rd_last_nxt = cp_addr_r == AddrW'(CopyN - 1);
          cp_done_nxt = rd_last_nxt;
          cp_addr_nxt = cp_addr_r + AddrW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      parity_r  <= 1'b0;
      flip_r    <= 1'b0;
      ovf_r     <= 1'b0;
      flicker_r <= 1'b0;
      valid_r   <= '0;
      cp_done_r <= 1'b0;
      rd_pend_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      parity_r  <= parity_nxt;
      flip_r    <= flip_nxt;
      ovf_r     <= ovf_nxt;
      flicker_r <= flicker_nxt;
      valid_r   <= valid_nxt;
      cp_done_r <= cp_done_nxt;
      rd_pend_r <= rd_pend_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_addr_r  <= cp_addr_nxt;
    rd_last_r  <= rd_last_nxt;
    out_kind_r <= out_kind_nxt;
    out_acc_r  <= out_acc_nxt;
    out_last_r <= out_last_nxt;
    out_ent_r  <= out_ent_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_be[0]) begin
        mem[wr_addr].y <= wr_data.y;
      end
      if (wr_be[1]) begin
        mem[wr_addr].x <= wr_data.x;
      end
      if (wr_be[2]) begin
        mem[wr_addr].tile <= wr_data.tile;
      end
      if (wr_be[3]) begin
        mem[wr_addr].attr <= wr_data.attr;
      end
    end
    if (rd_en) begin
      rdata_r  <= mem[cp_addr_r];
      rvalid_r <= valid_r[cp_addr_r];
    end
  end

endmodule
